// File: hdl/rlss_pkg.sv
package rlss_pkg;

   // Register and field widths
   localparam int REG_BITS      = 16;
   localparam int FUNC_BITS     = 2;
   localparam int DRAW_BITS     = 10;
   localparam int INDEX_BITS    = 4;
   localparam int NOTE_BITS     = 7;
   localparam int LEN_BITS      = 5;
   localparam int LSEL_BITS     = 3;
   localparam int OCT_BITS      = 2;
   localparam int SSEL_BITS     = 2;
   localparam int SIZE_BITS     = 3;
   localparam int SPAN_BITS     = 5;
   localparam int QUOT_BITS     = 5;
   localparam int STEP_BITS     = 3;
   localparam int STEP_NUM_BITS = 4;
   localparam int PROD_BITS     = REG_BITS + SPAN_BITS;
   localparam int CSR_IDX_BITS  = 2;
   localparam int CSR_DATA_BITS = 10;

   localparam logic [REG_BITS-1:0]  SEED_PATTERN  = 16'hA6C5;
   localparam logic [NOTE_BITS-1:0] ROOT_NOTE     = 7'd45;
   localparam logic [DRAW_BITS-1:0] PERMILLE_FULL = 10'd1000;

   localparam logic [DRAW_BITS-1:0] FLIP_RESET  = 10'd160;
   localparam logic [LSEL_BITS-1:0] LSEL_RESET  = 3'd6;
   localparam logic [OCT_BITS-1:0]  OCT_RESET   = 2'd2;
   localparam logic [SSEL_BITS-1:0] SSEL_RESET  = 2'd0;

   // Item operations
   localparam logic [FUNC_BITS-1:0] FUNC_TICK = 2'd0;
   localparam logic [FUNC_BITS-1:0] FUNC_FLIP = 2'd1;
   localparam logic [FUNC_BITS-1:0] FUNC_LOAD = 2'd2;

   // Configuration register indexes
   localparam logic [CSR_IDX_BITS-1:0] CSR_FLIP_PERMILLE = 2'd0;
   localparam logic [CSR_IDX_BITS-1:0] CSR_LENGTH_SELECT = 2'd1;
   localparam logic [CSR_IDX_BITS-1:0] CSR_OCTAVE_COUNT  = 2'd2;
   localparam logic [CSR_IDX_BITS-1:0] CSR_SCALE_SELECT  = 2'd3;

   typedef struct packed {
      logic [FUNC_BITS-1:0]  func;
      logic [DRAW_BITS-1:0]  random_draw;
      logic [INDEX_BITS-1:0] bit_index;
      logic [REG_BITS-1:0]   load_value;
   } req_payload_type;

   typedef struct packed {
      logic                 note_valid;
      logic [NOTE_BITS-1:0] note;
      logic                 kick;
      logic                 hat;
      logic [REG_BITS-1:0]  register_value;
   } rsp_payload_type;

   typedef struct packed {
      logic                 done;
      logic [QUOT_BITS-1:0] degree;
   } quant_result_type;

   typedef enum logic [1:0] {
      S_IDLE,
      S_QUANT,
      S_FINISH
   } seq_state_type;

   typedef enum logic [1:0] {
      Q_IDLE,
      Q_MUL,
      Q_DIV,
      Q_DONE
   } quant_state_type;

   // Loop length in bits; the unused select code acts as the longest loop
   function automatic logic [LEN_BITS-1:0] loop_length(input logic [LSEL_BITS-1:0] sel);
      logic [LEN_BITS-1:0] len;
      unique case (sel)
         3'd0:    len = 5'd3;
         3'd1:    len = 5'd4;
         3'd2:    len = 5'd5;
         3'd3:    len = 5'd6;
         3'd4:    len = 5'd8;
         3'd5:    len = 5'd12;
         default: len = 5'd16;
      endcase
      return len;
   endfunction

   // Degrees per octave: pentatonic scales have five, modes have seven
   function automatic logic [SIZE_BITS-1:0] scale_size(input logic [SSEL_BITS-1:0] sel);
      return sel[1] ? 3'd7 : 3'd5;
   endfunction

   // Semitone offset of a degree within the octave
   function automatic logic [STEP_NUM_BITS-1:0] scale_step(input logic [SSEL_BITS-1:0] sel,
                                                           input logic [2:0] idx);
      logic [STEP_NUM_BITS-1:0] step;
      step = 4'd0;
      unique case (sel)
         2'd0: begin
            unique case (idx)
               3'd1:    step = 4'd3;
               3'd2:    step = 4'd5;
               3'd3:    step = 4'd7;
               3'd4:    step = 4'd10;
               default: step = 4'd0;
            endcase
         end
         2'd1: begin
            unique case (idx)
               3'd1:    step = 4'd2;
               3'd2:    step = 4'd4;
               3'd3:    step = 4'd7;
               3'd4:    step = 4'd9;
               default: step = 4'd0;
            endcase
         end
         2'd2: begin
            unique case (idx)
               3'd1:    step = 4'd2;
               3'd2:    step = 4'd3;
               3'd3:    step = 4'd5;
               3'd4:    step = 4'd7;
               3'd5:    step = 4'd9;
               3'd6:    step = 4'd10;
               default: step = 4'd0;
            endcase
         end
         default: begin
            unique case (idx)
               3'd1:    step = 4'd2;
               3'd2:    step = 4'd3;
               3'd3:    step = 4'd5;
               3'd4:    step = 4'd7;
               3'd5:    step = 4'd8;
               3'd6:    step = 4'd10;
               default: step = 4'd0;
            endcase
         end
      endcase
      return step;
   endfunction

   // Map a clamped degree (below three octaves) to a MIDI note
   function automatic logic [NOTE_BITS-1:0] degree_to_note(input logic [QUOT_BITS-1:0] d,
                                                           input logic [SSEL_BITS-1:0] sel);
      logic [QUOT_BITS-1:0] n;
      logic [QUOT_BITS-1:0] rest;
      logic [NOTE_BITS-1:0] oct_semis;
      n = QUOT_BITS'(scale_size(sel));
      if (d >= (n << 1)) begin
         rest      = d - (n << 1);
         oct_semis = 7'd24;
      end else if (d >= n) begin
         rest      = d - n;
         oct_semis = 7'd12;
      end else begin
         rest      = d;
         oct_semis = 7'd0;
      end
      return ROOT_NOTE + oct_semis + NOTE_BITS'(scale_step(sel, rest[2:0]));
   endfunction

endpackage

// File: hdl/rlss_quant.sv
module rlss_quant (
   input  logic                                      clock,
   input  logic                                      reset,
   input  logic                                      start,
   input  logic [rlss_pkg::REG_BITS-1:0]             reg_value,
   input  logic [rlss_pkg::REG_BITS-1:0]             mask,
   input  logic [rlss_pkg::SPAN_BITS-1:0]            span,
   output rlss_pkg::quant_result_type                result
);
   import rlss_pkg::*;

   quant_state_type        state_ff, state_in;
   logic [REG_BITS-1:0]    value_ff, value_in;
   logic [REG_BITS-1:0]    mask_ff, mask_in;
   logic [SPAN_BITS-1:0]   span_ff, span_in;
   logic [PROD_BITS-1:0]   rem_ff, rem_in;
   logic [QUOT_BITS-1:0]   quot_ff, quot_in;
   logic [STEP_BITS-1:0]   step_ff, step_in;
   logic [PROD_BITS-1:0]   trial;

   // Next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         Q_IDLE:  if (start) state_in = Q_MUL;
         Q_MUL:   state_in = Q_DIV;
         Q_DIV:   if (step_ff == '0) state_in = Q_DONE;
         Q_DONE:  state_in = Q_IDLE;
         default: state_in = Q_IDLE;
      endcase
   end

   // Multiply once, then restore one quotient bit a cycle
   always_comb begin
      value_in = value_ff;
      mask_in  = mask_ff;
      span_in  = span_ff;
      rem_in   = rem_ff;
      quot_in  = quot_ff;
      step_in  = step_ff;
      trial    = PROD_BITS'(mask_ff) << step_ff;
      unique case (state_ff)
         Q_IDLE: begin
            if (start) begin
               value_in = reg_value;
               mask_in  = mask;
               span_in  = span;
            end
         end
         Q_MUL: begin
            rem_in  = PROD_BITS'(value_ff) * PROD_BITS'(span_ff);
            quot_in = '0;
            step_in = STEP_BITS'(QUOT_BITS - 1);
         end
         Q_DIV: begin
            if (rem_ff >= trial) begin
               rem_in           = rem_ff - trial;
               quot_in[step_ff] = 1'b1;
            end
            step_in = step_ff - 1'b1;
         end
         default: begin
         end
      endcase
   end

   // Clamp a full register to the top degree
   always_comb begin
      result.done   = (state_ff == Q_DONE);
      result.degree = (quot_ff >= span_ff) ? (span_ff - 1'b1) : quot_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= Q_IDLE;
      end else begin
         state_ff <= state_in;
      end
      value_ff <= value_in;
      mask_ff  <= mask_in;
      span_ff  <= span_in;
      rem_ff   <= rem_in;
      quot_ff  <= quot_in;
      step_ff  <= step_in;
   end

endmodule

// File: hdl/random_looping_shift_sequencer.sv
// Random looping shift sequencer.
// Request channel (req_valid/req_ready/req_data) takes one word per item: a
// clock tick, a flip of one loop bit, or a load of the register. Each item
// gives exactly one response word on rsp_valid/rsp_ready/rsp_data, carrying
// the register after the item and, for a tick, the quantized note and the
// kick and hat triggers.
// A tick's response word passes the 16x5 multiply, the restoring divider at
// one quotient bit a cycle, the clamp of the degree and its mapping to a
// note, and the load of the output register. Flip and load words skip the
// quantizer and go to the output register. One item is in progress at a
// time; req_ready returns high together with rsp_valid, so no new word is
// taken until the last response word is in the output register.
// A finished response waits in the output register while the next word is
// accepted; if the receiver still stalls when that next item finishes, the
// block holds it and keeps req_ready low until the output register frees.
// Reset (synchronous) loads the seed pattern 0xA6C5 and the default settings
// and empties the output register. The csr_ port writes a setting at each
// edge out of reset with csr_we high. Settings are to be changed only while
// the block is idle; this binds the user and is not enforced by the block.
module random_looping_shift_sequencer (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_valid,
   output logic                                  req_ready,
   input  rlss_pkg::req_payload_type             req_data,
   output logic                                  rsp_valid,
   input  logic                                  rsp_ready,
   output rlss_pkg::rsp_payload_type             rsp_data,
   input  logic                                  csr_we,
   input  logic [rlss_pkg::CSR_IDX_BITS-1:0]     csr_index,
   input  logic [rlss_pkg::CSR_DATA_BITS-1:0]    csr_wdata
);
   import rlss_pkg::*;

   seq_state_type          state_ff, state_in;
   logic [REG_BITS-1:0]    shift_ff, shift_in;
   logic [DRAW_BITS-1:0]   flip_permille_ff;
   logic [LSEL_BITS-1:0]   length_select_ff;
   logic [OCT_BITS-1:0]    octave_count_ff;
   logic [SSEL_BITS-1:0]   scale_select_ff;
   rsp_payload_type        res_ff, res_in;
   rsp_payload_type        rsp_data_ff, rsp_data_in;
   logic                   rsp_valid_ff, rsp_valid_in;

   logic                   req_accept;
   logic                   is_tick;
   logic                   load_out;
   logic                   quant_start;
   quant_result_type       quant_result;

   logic [LEN_BITS-1:0]    len;
   logic [REG_BITS-1:0]    mask;
   logic [OCT_BITS-1:0]    oct_eff;
   logic [SPAN_BITS-1:0]   span;
   logic                   feedback;
   logic [REG_BITS-1:0]    ticked;

   assign req_accept = req_valid && req_ready;
   assign is_tick    = (req_data.func == FUNC_TICK);

   // Next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (req_accept) state_in = is_tick ? S_QUANT : S_FINISH;
         end
         S_QUANT: begin
            if (quant_result.done) state_in = S_FINISH;
         end
         S_FINISH: begin
            if (!rsp_valid_ff || rsp_ready) state_in = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   // Handshake controls
   always_comb begin
      req_ready   = (state_ff == S_IDLE);
      quant_start = (state_ff == S_IDLE) && req_accept && is_tick;
      load_out    = (state_ff == S_FINISH) && (!rsp_valid_ff || rsp_ready);
   end

   // Loop geometry and quantizer span from the settings
   always_comb begin
      len      = loop_length(length_select_ff);
      mask     = REG_BITS'((17'd1 << len) - 17'd1);
      oct_eff  = (octave_count_ff == '0) ? OCT_BITS'(1) : octave_count_ff;
      span     = SPAN_BITS'(oct_eff) * SPAN_BITS'(scale_size(scale_select_ff));
      feedback = shift_ff[INDEX_BITS'(len - 1'b1)];
      if ((flip_permille_ff >= PERMILLE_FULL) || (req_data.random_draw < flip_permille_ff))
         feedback = ~feedback;
      ticked   = {shift_ff[REG_BITS-2:0], feedback} & mask;
   end

   // Update the register and build the response word
   always_comb begin
      shift_in = shift_ff;
      res_in   = res_ff;
      if (req_accept) begin
         priority case (req_data.func)
            FUNC_TICK: shift_in = ticked;
            FUNC_FLIP: begin
               if (LEN_BITS'(req_data.bit_index) < len)
                  shift_in = shift_ff ^ (REG_BITS'(1) << req_data.bit_index);
            end
            FUNC_LOAD: shift_in = req_data.load_value;
            default:   shift_in = shift_ff;
         endcase
         res_in.note_valid     = is_tick;
         res_in.note           = '0;
         res_in.kick           = is_tick & shift_in[0];
         res_in.hat            = is_tick & shift_in[2];
         res_in.register_value = shift_in;
      end
      if ((state_ff == S_QUANT) && quant_result.done)
         res_in.note = degree_to_note(quant_result.degree, scale_select_ff);
   end

   // Output register: load a finished word, drop it when taken
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      if (rsp_valid_ff && rsp_ready) rsp_valid_in = 1'b0;
      if (load_out) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = res_ff;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   rlss_quant u_quant (
      .clock     (clock),
      .reset     (reset),
      .start     (quant_start),
      .reg_value (ticked),
      .mask      (mask),
      .span      (span),
      .result    (quant_result)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff         <= S_IDLE;
         shift_ff         <= SEED_PATTERN;
         rsp_valid_ff     <= 1'b0;
         flip_permille_ff <= FLIP_RESET;
         length_select_ff <= LSEL_RESET;
         octave_count_ff  <= OCT_RESET;
         scale_select_ff  <= SSEL_RESET;
      end else begin
         state_ff     <= state_in;
         shift_ff     <= shift_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_we) begin
            unique case (csr_index)
               CSR_FLIP_PERMILLE: flip_permille_ff <= csr_wdata;
               CSR_LENGTH_SELECT: length_select_ff <= csr_wdata[LSEL_BITS-1:0];
               CSR_OCTAVE_COUNT:  octave_count_ff  <= csr_wdata[OCT_BITS-1:0];
               CSR_SCALE_SELECT:  scale_select_ff  <= csr_wdata[SSEL_BITS-1:0];
               default: begin
               end
            endcase
         end
      end
      res_ff      <= res_in;
      rsp_data_ff <= rsp_data_in;
   end

endmodule

// File: sim/rlss_checker.sv
`timescale 1ns / 1ps

module rlss_checker (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   input  logic                       req_ready,
   input  rlss_pkg::req_payload_type  req_data,
   input  logic                       rsp_valid,
   input  logic                       rsp_ready,
   input  rlss_pkg::rsp_payload_type  rsp_data,
   input  logic                       csr_we,
   input  logic [rlss_pkg::CSR_IDX_BITS-1:0]  csr_index,
   input  logic [rlss_pkg::CSR_DATA_BITS-1:0] csr_wdata,
   output int                         mismatch_count,
   output int                         pending_count,
   output int                         result_count,
   output int                         note_count
);

   import rlss_pkg::*;

   localparam int REPORT_LIMIT = 10;

   // Semitone offsets per degree, one nibble each, degree 0 in the low nibble
   localparam logic [27:0] MINOR_PENT_STEPS = {4'd0, 4'd0, 4'd10, 4'd7, 4'd5, 4'd3, 4'd0};
   localparam logic [27:0] MAJOR_PENT_STEPS = {4'd0, 4'd0, 4'd9, 4'd7, 4'd4, 4'd2, 4'd0};
   localparam logic [27:0] DORIAN_STEPS     = {4'd10, 4'd9, 4'd7, 4'd5, 4'd3, 4'd2, 4'd0};
   localparam logic [27:0] AEOLIAN_STEPS    = {4'd10, 4'd8, 4'd7, 4'd5, 4'd3, 4'd2, 4'd0};

   // Own copy of the loop and its settings
   logic [REG_BITS-1:0]  loop_reg;
   logic [DRAW_BITS-1:0] flip_setting;
   logic [LSEL_BITS-1:0] length_code;
   logic [OCT_BITS-1:0]  octave_code;
   logic [SSEL_BITS-1:0] scale_code;

   // Response words still owed by the block, oldest first
   rsp_payload_type note_words[$];

   int errors  = 0;
   int results = 0;
   int notes   = 0;

   // Apply one request word to the loop and return the response it owes
   function automatic rsp_payload_type step_loop(input req_payload_type w);
      rsp_payload_type r;
      int unsigned     len;
      int unsigned     full;
      int unsigned     octaves;
      int unsigned     per_octave;
      int unsigned     span;
      int unsigned     degree;
      logic [27:0]     steps;
      logic            fed_back;
      r = '0;
      case (length_code)
         3'd0:    len = 3;
         3'd1:    len = 4;
         3'd2:    len = 5;
         3'd3:    len = 6;
         3'd4:    len = 8;
         3'd5:    len = 12;
         default: len = 16;
      endcase
      full = (32'd1 << len) - 32'd1;
      case (w.func)
         FUNC_TICK: begin
            // recirculate the top loop bit, inverted on a hit
            fed_back = loop_reg[len-1];
            if (flip_setting >= PERMILLE_FULL || w.random_draw < flip_setting)
               fed_back = ~fed_back;
            loop_reg = REG_BITS'({loop_reg, fed_back} & full);
            // quantise to a degree, clamp the full register to the top degree
            octaves    = (octave_code == 2'd0) ? 1 : octave_code;
            per_octave = scale_code[1] ? 7 : 5;
            span       = octaves * per_octave;
            degree     = (loop_reg * span) / full;
            if (degree >= span)
               degree = span - 1;
            case (scale_code)
               2'd0:    steps = MINOR_PENT_STEPS;
               2'd1:    steps = MAJOR_PENT_STEPS;
               2'd2:    steps = DORIAN_STEPS;
               default: steps = AEOLIAN_STEPS;
            endcase
            r.note_valid = 1'b1;
            r.note = NOTE_BITS'(ROOT_NOTE + 12 * (degree / per_octave)
                                + steps[(degree % per_octave) * 4 +: 4]);
            r.kick = loop_reg[0];
            r.hat  = loop_reg[2];
         end
         FUNC_FLIP: begin
            // bits beyond the loop are left alone
            if (w.bit_index < len)
               loop_reg[w.bit_index] = ~loop_reg[w.bit_index];
         end
         FUNC_LOAD: begin
            loop_reg = w.load_value;
         end
         default: begin
         end
      endcase
      r.register_value = loop_reg;
      return r;
   endfunction

   // Track settings, predict on each accepted request, compare each response
   always @(posedge clock) begin
      rsp_payload_type want;
      if (reset) begin
         loop_reg     = SEED_PATTERN;
         flip_setting = FLIP_RESET;
         length_code  = LSEL_RESET;
         octave_code  = OCT_RESET;
         scale_code   = SSEL_RESET;
         note_words.delete();
      end else begin
         if (csr_we) begin
            case (csr_index)
               CSR_FLIP_PERMILLE: flip_setting = csr_wdata;
               CSR_LENGTH_SELECT: length_code  = csr_wdata[LSEL_BITS-1:0];
               CSR_OCTAVE_COUNT:  octave_code  = csr_wdata[OCT_BITS-1:0];
               CSR_SCALE_SELECT:  scale_code   = csr_wdata[SSEL_BITS-1:0];
               default: begin
               end
            endcase
         end
         if (rsp_valid && rsp_ready) begin
            results++;
            if (note_words.size() == 0) begin
               errors++;
               if (errors <= REPORT_LIMIT)
                  $display("%0t: response word with none owed: reg=%h", $time,
                           rsp_data.register_value);
            end else begin
               want = note_words.pop_front();
               if (want.note_valid)
                  notes++;
               if (rsp_data.note_valid !== want.note_valid || rsp_data.note !== want.note ||
                   rsp_data.kick !== want.kick || rsp_data.hat !== want.hat ||
                   rsp_data.register_value !== want.register_value) begin
                  errors++;
                  if (errors <= REPORT_LIMIT) begin
                     $display("%0t: response %0d expected valid=%0b note=%0d kick=%0b %s",
                              $time, results, want.note_valid, want.note, want.kick,
                              $sformatf("hat=%0b reg=%h", want.hat, want.register_value));
                     $display("   got valid=%0b note=%0d kick=%0b hat=%0b reg=%h",
                              rsp_data.note_valid, rsp_data.note, rsp_data.kick,
                              rsp_data.hat, rsp_data.register_value);
                  end
               end
            end
         end
         if (req_valid && req_ready)
            note_words.push_back(step_loop(req_data));
      end
      mismatch_count <= errors;
      pending_count  <= note_words.size();
      result_count   <= results;
      note_count     <= notes;
   end

endmodule

// File: sim/tb_random_looping_shift_sequencer.sv
`timescale 1ns / 1ps

module tb_random_looping_shift_sequencer;

   import rlss_pkg::*;

   // The spare operation code has no name in the package
   localparam logic [FUNC_BITS-1:0] FUNC_SPARE = 2'd3;

   localparam int PHASES         = 15;
   localparam int PHASE_WORDS    = 110;
   localparam int SETTLE_CYCLES  = 20;
   localparam int WATCHDOG_LIMIT = 2000;

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic                       req_valid = 1'b0;
   logic                       req_ready;
   req_payload_type            req_data  = '0;
   logic                       rsp_valid;
   logic                       rsp_ready = 1'b0;
   rsp_payload_type            rsp_data;
   logic                       csr_we    = 1'b0;
   logic [CSR_IDX_BITS-1:0]    csr_index = CSR_FLIP_PERMILLE;
   logic [CSR_DATA_BITS-1:0]   csr_wdata = '0;

   int mismatch_count;
   int pending_count;
   int result_count;
   int note_count;

   int          words_sent    = 0;
   int          setting_count = 1;
   int          idle_cycles   = 0;
   logic [11:0] stall_cycle   = '0;
   int          hold_left     = 0;

   req_payload_type word_q[$];

   random_looping_shift_sequencer dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   rlss_checker u_checker (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_data       (req_data),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_data       (rsp_data),
      .csr_we         (csr_we),
      .csr_index      (csr_index),
      .csr_wdata      (csr_wdata),
      .mismatch_count (mismatch_count),
      .pending_count  (pending_count),
      .result_count   (result_count),
      .note_count     (note_count)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Stall the response side: free running, coin toss, fixed pattern, long holds
   always @(posedge clock) begin
      stall_cycle <= stall_cycle + 1'b1;
      case (stall_cycle[11:10])
         2'd0: rsp_ready <= 1'b1;
         2'd1: rsp_ready <= 1'($urandom_range(0, 1));
         2'd2: rsp_ready <= (stall_cycle[3:0] >= 4'd5);
         default: begin
            if (hold_left != 0) begin
               hold_left <= hold_left - 1;
               rsp_ready <= 1'b0;
            end else begin
               rsp_ready <= 1'b1;
               if ($urandom_range(0, 7) == 0)
                  hold_left <= $urandom_range(1, 40);
            end
         end
      endcase
   end

   // End the run when no word moves on either channel for too long
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready))
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("Watchdog: no word moved for %0d cycles", idle_cycles);
         $display("RESULT: ERROR");
         $finish;
      end
   end

   function automatic req_payload_type pack_word(input logic [FUNC_BITS-1:0] func,
                                                 input int unsigned draw,
                                                 input int unsigned index,
                                                 input logic [REG_BITS-1:0] load);
      req_payload_type w;
      w.func        = func;
      w.random_draw = DRAW_BITS'(draw);
      w.bit_index   = INDEX_BITS'(index);
      w.load_value  = load;
      return w;
   endfunction

   // Mostly ticks, with flips, loads, spare codes and the odd out-of-range draw
   function automatic req_payload_type random_word();
      int unsigned            pick;
      int unsigned            draw;
      logic [FUNC_BITS-1:0]   func;
      pick = $urandom_range(0, 99);
      if (pick < 55)
         func = FUNC_TICK;
      else if (pick < 70)
         func = FUNC_FLIP;
      else if (pick < 88)
         func = FUNC_LOAD;
      else
         func = FUNC_SPARE;
      if ($urandom_range(0, 15) == 0)
         draw = $urandom_range(1000, 1023);
      else
         draw = $urandom_range(0, 999);
      return pack_word(func, draw, $urandom_range(0, 15), REG_BITS'($urandom()));
   endfunction

   // Send the queued words in bursts of random length with random gaps
   task automatic drive_words();
      int burst_left;
      burst_left = 0;
      foreach (word_q[i]) begin
         if (burst_left == 0) begin
            req_valid <= 1'b0;
            repeat ($urandom_range(1, 12)) @(posedge clock);
            if ($urandom_range(0, 3) == 0)
               burst_left = $urandom_range(40, 80);
            else
               burst_left = $urandom_range(1, 8);
         end
         req_valid <= 1'b1;
         req_data  <= word_q[i];
         @(posedge clock);
         while (!req_ready)
            @(posedge clock);
         burst_left--;
         words_sent++;
      end
      req_valid <= 1'b0;
      word_q.delete();
   endtask

   // Hold off until every owed response is in and the block has gone quiet
   task automatic wait_drained();
      @(posedge clock);
      while (pending_count != 0)
         @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_settings(input int unsigned flip, input int unsigned lsel,
                                 input int unsigned oct, input int unsigned ssel);
      csr_we    <= 1'b1;
      csr_index <= CSR_FLIP_PERMILLE;
      csr_wdata <= CSR_DATA_BITS'(flip);
      @(posedge clock);
      csr_index <= CSR_LENGTH_SELECT;
      csr_wdata <= CSR_DATA_BITS'(lsel);
      @(posedge clock);
      csr_index <= CSR_OCTAVE_COUNT;
      csr_wdata <= CSR_DATA_BITS'(oct);
      @(posedge clock);
      csr_index <= CSR_SCALE_SELECT;
      csr_wdata <= CSR_DATA_BITS'(ssel);
      @(posedge clock);
      csr_we    <= 1'b0;
      setting_count++;
   endtask

   initial begin
      int unsigned flip;
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      for (int p = 0; p < PHASES; p++) begin
         // Pick the settings: defaults first, then the extremes, then random
         case (p)
            0: begin
               // Default loop of 16 bits: draws round the flip threshold,
               // loads to empty and full, flips at both ends, the spare code
               word_q.push_back(pack_word(FUNC_TICK, 0, 0, 16'h0000));
               word_q.push_back(pack_word(FUNC_TICK, 159, 0, 16'h0000));
               word_q.push_back(pack_word(FUNC_TICK, 160, 0, 16'h0000));
               word_q.push_back(pack_word(FUNC_TICK, 999, 0, 16'h0000));
               word_q.push_back(pack_word(FUNC_TICK, 1000, 0, 16'h0000));
               word_q.push_back(pack_word(FUNC_TICK, 1023, 15, 16'hFFFF));
               word_q.push_back(pack_word(FUNC_FLIP, 0, 0, 16'h0000));
               word_q.push_back(pack_word(FUNC_FLIP, 0, 15, 16'h0000));
               word_q.push_back(pack_word(FUNC_SPARE, 1023, 15, 16'hFFFF));
               word_q.push_back(pack_word(FUNC_LOAD, 0, 0, 16'h0000));
               word_q.push_back(pack_word(FUNC_TICK, 999, 0, 16'h0000));
               word_q.push_back(pack_word(FUNC_LOAD, 0, 0, 16'hFFFF));
               word_q.push_back(pack_word(FUNC_TICK, 999, 0, 16'h0000));
               word_q.push_back(pack_word(FUNC_LOAD, 0, 0, 16'h5A5A));
               word_q.push_back(pack_word(FUNC_FLIP, 0, 7, 16'h0000));
               word_q.push_back(pack_word(FUNC_TICK, 500, 0, 16'h0000));
               word_q.push_back(pack_word(FUNC_LOAD, 0, 0, 16'hA5A5));
               word_q.push_back(pack_word(FUNC_TICK, 0, 0, 16'h0000));
            end
            1: begin
               // Locked 3-bit loop: unmasked load, flip past the loop, full loop
               write_settings(0, 0, 1, 0);
               word_q.push_back(pack_word(FUNC_LOAD, 0, 0, 16'hFFFF));
               word_q.push_back(pack_word(FUNC_TICK, 1023, 0, 16'h0000));
               word_q.push_back(pack_word(FUNC_FLIP, 0, 3, 16'h0000));
               word_q.push_back(pack_word(FUNC_FLIP, 0, 2, 16'h0000));
               word_q.push_back(pack_word(FUNC_TICK, 0, 0, 16'h0000));
               word_q.push_back(pack_word(FUNC_LOAD, 0, 0, 16'h0007));
               word_q.push_back(pack_word(FUNC_TICK, 500, 0, 16'h0000));
            end
            2: begin
               // Flip-lock over three octaves of aeolian
               write_settings(1000, 6, 3, 3);
               word_q.push_back(pack_word(FUNC_TICK, 999, 0, 16'h0000));
               word_q.push_back(pack_word(FUNC_TICK, 1023, 0, 16'h0000));
            end
            3: begin
               // Out-of-range codes: flip above full, spare length, zero octaves
               write_settings(1023, 7, 0, 2);
               word_q.push_back(pack_word(FUNC_TICK, 1023, 0, 16'h0000));
            end
            4: write_settings(999, 3, 2, 1);
            default: begin
               if ($urandom_range(0, 7) == 0)
                  flip = $urandom_range(1001, 1023);
               else
                  flip = $urandom_range(0, 1000);
               write_settings(flip, $urandom_range(0, 7), $urandom_range(0, 3),
                              $urandom_range(0, 3));
            end
         endcase

         repeat (PHASE_WORDS) word_q.push_back(random_word());
         drive_words();
         wait_drained();
      end

      $display("Sent %0d request words over %0d register settings;", words_sent,
               setting_count);
      $display("checked %0d responses, %0d of them notes.", result_count, note_count);
      if (mismatch_count == 0 && pending_count == 0)
         $display("RESULT: OK");
      else
         $display("RESULT: ERROR");
      $finish;
   end

endmodule

// File: random_looping_shift_sequencer.f
hdl/rlss_pkg.sv
hdl/rlss_quant.sv
hdl/random_looping_shift_sequencer.sv
sim/rlss_checker.sv
sim/tb_random_looping_shift_sequencer.sv
